[rtl/core/mixed_precision_muldiv_unit_assert.svh]
// Assertion macros for the mixed-precision multiply/divide unit.
`ifndef MIXED_PRECISION_MULDIV_UNIT_ASSERT_SVH
`define MIXED_PRECISION_MULDIV_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define MPMD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define MPMD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error("assertion failed");
`else
`define MPMD_ASSERT(label, clk, rst_n, prop)
`define MPMD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/mpmd_pkg.sv]
// Shared types and constants of the mixed-precision multiply/divide unit.
package mpmd_pkg;

  typedef enum logic [2:0] {
    CMD_STAR_SLASH,
    CMD_STAR_SLASH_MOD,
    CMD_SYM_DIV,
    CMD_FLOOR_DIV,
    CMD_UDIV,
    CMD_UMULDIV,
    CMD_SMULDIV,
    CMD_NOP
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_DIV_ZERO,
    ST_RANGE
  } status_e;

  localparam int DivBits   = 48;
  localparam int QBits     = DivBits + 2;
  // decode, multiply, one stage per quotient bit, three post stages
  localparam int NumStages = DivBits + 5;

  localparam logic signed [QBits-1:0] S16Min = -QBits'(32768);
  localparam logic signed [QBits-1:0] S16Max = QBits'(32767);
  localparam logic signed [QBits-1:0] U16Max = QBits'(65535);
  localparam logic signed [QBits-1:0] U32Max = QBits'(64'hFFFF_FFFF);
  localparam logic signed [QBits-1:0] S32Min = -QBits'(64'h8000_0000);
  localparam logic signed [QBits-1:0] S32Max = QBits'(64'h7FFF_FFFF);

  typedef struct packed {
    cmd_e cmd;
    logic neg_q;
    logic neg_n;
    logic neg_c;
    logic dz;
  } meta_t;

  typedef struct packed {
    logic [DivBits-1:0] nq;
    logic [15:0]        rem;
    logic [15:0]        dmag;
    meta_t              meta;
  } div_t;

endpackage

[rtl/core/mpmd_front.sv]
// Operand decode to magnitudes and the 32x16 magnitude multiply.
module mpmd_front (
  input  logic            clk_i,
  input  logic            en0_i,
  input  logic            en1_i,
  input  mpmd_pkg::cmd_e  cmd_i,
  input  logic [31:0]     wide_i,
  input  logic [15:0]     factor_i,
  input  logic [15:0]     divisor_i,
  output mpmd_pkg::div_t  div_o
);
  import mpmd_pkg::*;

  typedef struct packed {
    logic [31:0] ma;
    logic [15:0] mb;
    logic [15:0] dmag;
    meta_t       meta;
  } dec_t;

  dec_t dec_d, dec_q;
  div_t div_d, div_q;
  logic [15:0] wl_abs, f_abs, d_abs;
  logic [31:0] w_abs;

  always_comb begin
    wl_abs = wide_i[15] ? (~wide_i[15:0] + 16'd1) : wide_i[15:0];
    w_abs  = wide_i[31] ? (~wide_i + 32'd1) : wide_i;
    f_abs  = factor_i[15] ? (~factor_i + 16'd1) : factor_i;
    d_abs  = divisor_i[15] ? (~divisor_i + 16'd1) : divisor_i;
    dec_d = '0;
    dec_d.meta.cmd = cmd_i;
    dec_d.meta.dz  = (divisor_i == 16'd0);
    dec_d.dmag     = divisor_i;
    unique case (cmd_i)
      CMD_STAR_SLASH, CMD_STAR_SLASH_MOD: begin
        dec_d.ma         = {16'd0, wl_abs};
        dec_d.mb         = f_abs;
        dec_d.meta.neg_n = wide_i[15] ^ factor_i[15];
        dec_d.meta.neg_c = divisor_i[15];
        dec_d.dmag       = d_abs;
      end
      CMD_SYM_DIV, CMD_FLOOR_DIV: begin
        dec_d.ma         = w_abs;
        dec_d.mb         = 16'd1;
        dec_d.meta.neg_n = wide_i[31];
        dec_d.meta.neg_c = divisor_i[15];
        dec_d.dmag       = d_abs;
      end
      CMD_UDIV: begin
        dec_d.ma = wide_i;
        dec_d.mb = 16'd1;
      end
      CMD_UMULDIV: begin
        dec_d.ma = wide_i;
        dec_d.mb = factor_i;
      end
      CMD_SMULDIV: begin
        dec_d.ma         = w_abs;
        dec_d.mb         = f_abs;
        dec_d.meta.neg_n = wide_i[31] ^ factor_i[15];
      end
      CMD_NOP: begin
        dec_d.ma = 32'd0;
        dec_d.mb = 16'd0;
      end
      default: dec_d.ma = 32'd0;
    endcase
    dec_d.meta.neg_q = dec_d.meta.neg_n ^ dec_d.meta.neg_c;
  end

  always_ff @(posedge clk_i) begin
    if (en0_i) begin
      dec_q <= dec_d;
    end
  end

  always_comb begin
    div_d      = '0;
    // widen both factors so the full 48-bit product is kept
    div_d.nq   = {16'd0, dec_q.ma} * {32'd0, dec_q.mb};
    div_d.rem  = 16'd0;
    div_d.dmag = dec_q.dmag;
    div_d.meta = dec_q.meta;
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;
endmodule

[rtl/core/mpmd_div_step.sv]
// One restoring-division stage: retire one quotient bit.
module mpmd_div_step (
  input  logic           clk_i,
  input  logic           en_i,
  input  mpmd_pkg::div_t stg_i,
  output mpmd_pkg::div_t stg_o
);
  import mpmd_pkg::*;

  div_t        stg_d, stg_q;
  logic [16:0] trial, diff;
  logic        ge;

  always_comb begin
    trial  = {stg_i.rem, stg_i.nq[DivBits-1]};
    diff   = trial - {1'b0, stg_i.dmag};
    ge     = (trial >= {1'b0, stg_i.dmag});
    stg_d     = stg_i;
    stg_d.nq  = {stg_i.nq[DivBits-2:0], ge};
    stg_d.rem = ge ? diff[15:0] : trial[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q <= stg_d;
    end
  end

  assign stg_o = stg_q;
endmodule

[rtl/core/mpmd_post.sv]
// Sign restore, flooring, range check and result formatting.
module mpmd_post (
  input  logic                clk_i,
  input  logic [2:0]          en_i,
  input  mpmd_pkg::div_t      div_i,
  output logic [31:0]         quotient_o,
  output logic [15:0]         remainder_o,
  output mpmd_pkg::status_e   status_o
);
  import mpmd_pkg::*;

  typedef struct packed {
    logic signed [QBits-1:0] q;
    logic signed [16:0]      r;
    logic signed [16:0]      c;
    logic                    floor_adj;
    meta_t                   meta;
  } sgn_t;

  typedef struct packed {
    logic signed [QBits-1:0] q;
    logic signed [16:0]      r;
    meta_t                   meta;
  } adj_t;

  sgn_t sgn_d, sgn_q;
  adj_t adj_d, adj_q;
  logic [31:0] quo_d, quo_q;
  logic [15:0] rem_d, rem_q;
  status_e     st_d, st_q;
  logic        bad;

  always_comb begin
    sgn_d.meta = div_i.meta;
    sgn_d.q = div_i.meta.neg_q ? -$signed({2'b00, div_i.nq}) : $signed({2'b00, div_i.nq});
    sgn_d.r = div_i.meta.neg_n ? -$signed({1'b0, div_i.rem}) : $signed({1'b0, div_i.rem});
    sgn_d.c = div_i.meta.neg_c ? -$signed({1'b0, div_i.dmag}) : $signed({1'b0, div_i.dmag});
    // floored division pulls a nonzero remainder over to the divisor's sign
    sgn_d.floor_adj = (div_i.meta.cmd == CMD_FLOOR_DIV) && (div_i.rem != 16'd0) &&
                      (div_i.meta.neg_n != div_i.meta.neg_c);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sgn_q <= sgn_d;
    end
  end

  always_comb begin
    adj_d.meta = sgn_q.meta;
    adj_d.q    = sgn_q.floor_adj ? (sgn_q.q - QBits'(1)) : sgn_q.q;
    adj_d.r    = sgn_q.floor_adj ? (sgn_q.r + sgn_q.c) : sgn_q.r;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      adj_q <= adj_d;
    end
  end

  always_comb begin
    quo_d = {16'd0, adj_q.q[15:0]};
    rem_d = adj_q.r[15:0];
    bad   = 1'b0;
    unique case (adj_q.meta.cmd)
      CMD_STAR_SLASH: begin
        rem_d = 16'd0;
        bad   = (adj_q.q < S16Min) || (adj_q.q > S16Max);
      end
      CMD_STAR_SLASH_MOD, CMD_SYM_DIV, CMD_FLOOR_DIV: begin
        bad = (adj_q.q < S16Min) || (adj_q.q > S16Max);
      end
      CMD_UDIV: begin
        bad = (adj_q.q > U16Max);
      end
      CMD_UMULDIV: begin
        quo_d = adj_q.q[31:0];
        rem_d = 16'd0;
        bad   = (adj_q.q > U32Max);
      end
      CMD_SMULDIV: begin
        quo_d = adj_q.q[31:0];
        rem_d = 16'd0;
        bad   = (adj_q.q < S32Min) || (adj_q.q > S32Max);
      end
      CMD_NOP: begin
        quo_d = 32'd0;
        rem_d = 16'd0;
      end
      default: bad = 1'b0;
    endcase
    st_d = bad ? ST_RANGE : ST_OK;
    if (adj_q.meta.cmd != CMD_NOP && adj_q.meta.dz) begin
      quo_d = 32'd0;
      rem_d = 16'd0;
      st_d  = ST_DIV_ZERO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      st_q  <= st_d;
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign status_o    = st_q;
endmodule

[rtl/core/mixed_precision_muldiv_unit.sv]
// Mixed-precision 16/32-bit multiply/divide unit, top level.
// This unit runs seven Forth-style arithmetic commands (star-slash, star-slash-mod,
// symmetric, floored and unsigned 32/16 division, unsigned and signed 32x16/16
// multiply-divide) through a 53-stage pipeline: one decode stage that turns all
// operands into magnitudes, one 32x16 multiply stage, 48 restoring-division
// stages that each retire one quotient bit of the 48-bit magnitude dividend, and
// three stages that restore signs, apply flooring and check the quotient range.
// An item enters every cycle unless the pipeline is full and the output stalled.
// Each stage holds while the one after it is full and stalled, so bubbles are
// squeezed out and input keeps flowing while a result waits at the output.
// Status flags a zero divisor (quotient and remainder zero) or an out-of-range
// quotient (low bits still given).
`include "mixed_precision_muldiv_unit_assert.svh"

module mixed_precision_muldiv_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // wide_operand[31:0], factor[47:32], divisor[63:48]
  input  logic [2:0]  s_axis_tuser_i,  // cmd[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // quotient[31:0], remainder[47:32]
  output logic [1:0]  m_axis_tuser_o   // status[1:0]
);
  import mpmd_pkg::*;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;
  div_t                 stg [DivBits+1];
  logic [31:0]          quotient;
  logic [15:0]          remainder;
  status_e              status;

  // a stage advances when empty or when its successor advances
  for (genvar k = 0; k < NumStages - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end
  assign en[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  mpmd_front u_front (
    .clk_i     (clk_i),
    .en0_i     (en[0]),
    .en1_i     (en[1]),
    .cmd_i     (cmd_e'(s_axis_tuser_i)),
    .wide_i    (s_axis_tdata_i[31:0]),
    .factor_i  (s_axis_tdata_i[47:32]),
    .divisor_i (s_axis_tdata_i[63:48]),
    .div_o     (stg[0])
  );

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < DivBits; i++) begin : g_div
    mpmd_div_step u_step (
      .clk_i (clk_i),
      .en_i  (en[i+2]),
      .stg_i (stg[i]),
      .stg_o (stg[i+1])
    );
  end

  mpmd_post u_post (
    .clk_i       (clk_i),
    .en_i        (en[NumStages-1:NumStages-3]),
    .div_i       (stg[DivBits]),
    .quotient_o  (quotient),
    .remainder_o (remainder),
    .status_o    (status)
  );

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = vld_q[NumStages-1];
  assign m_axis_tdata_o  = {remainder, quotient};
  assign m_axis_tuser_o  = status;

  // input only blocks when every stage is full and the output is stalled
  `MPMD_ASSERT_IMPLIES(a_stall_only_full, clk_i, rst_ni, !s_axis_tready_o, (&vld_q) && !m_axis_tready_i)
  // a zero divisor never leaves stray quotient or remainder bits
  `MPMD_ASSERT_IMPLIES(a_dz_zero, clk_i, rst_ni, m_axis_tvalid_o && (status == ST_DIV_ZERO), m_axis_tdata_o == 48'd0)
  // an accepted item lands in the first stage
  `MPMD_ASSERT_IMPLIES(a_enter, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, ##1 vld_q[0])
endmodule
